[rtl/cpvp_pkg.sv]
package cpvp_pkg;

  localparam int NCH        = 4;
  localparam int MOT_W      = 2;
  localparam int ENC_W      = 13;
  localparam int ENC_SHIFT  = 13;
  localparam int ENC_COUNTS = 1 << ENC_SHIFT;
  localparam int SPD_W      = 16;
  localparam int DRV_W      = 15;
  localparam int SPOS_W     = 32;
  localparam int TGT_W      = 21;
  localparam int DB_W       = 10;
  localparam int SLIM_W     = 14;
  localparam int PIL_W      = 20;
  localparam int CLIM_W     = 14;
  localparam int RAW_W      = 48;
  localparam int PI_W       = 21;
  localparam int VI_W       = 11;
  localparam int ERR_W      = 16;
  localparam int VTGT_W     = 15;
  localparam int PROD_W     = 36;
  localparam int ACC_W      = 38;
  localparam int KI_Q16     = 6554;
  localparam int VEL_I_LIM  = 1000;
  localparam int SETTLE_POS = 50;
  localparam int SETTLE_SPD = 100;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_TGT0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PI_LIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_LIM  = 3'd7;

  localparam logic [DB_W-1:0]   DEADBAND_RST = 10'd10;
  localparam logic [SLIM_W-1:0] SPD_LIM_RST  = 14'd3000;
  localparam logic [PIL_W-1:0]  PI_LIM_RST   = 20'd10000;
  localparam logic [CLIM_W-1:0] CUR_LIM_RST  = 14'd3000;

  typedef enum logic [2:0] {
    PH_RAW, PH_SCALE, PH_PERR, PH_PMUL, PH_PACC, PH_VERR, PH_VMUL, PH_VACC
  } phase_t;

  typedef struct packed {
    logic             load;
    logic             run;
    phase_t           phase;
    logic [MOT_W-1:0] motor;
    logic             publish;
  } cmd_t;

  typedef struct packed {
    logic [NCH-1:0][TGT_W-1:0] tgt;
    logic [DB_W-1:0]           deadband;
    logic [SLIM_W-1:0]         speed_limit;
    logic [PIL_W-1:0]          pi_limit;
    logic [CLIM_W-1:0]         current_limit;
  } cfg_t;

endpackage

[rtl/cpvp_in_if.sv]
interface cpvp_in_if;
  logic        valid;
  logic        ready;
  logic [12:0] enc_now_0;
  logic [12:0] enc_now_1;
  logic [12:0] enc_now_2;
  logic [12:0] enc_now_3;
  logic [12:0] enc_prev_0;
  logic [12:0] enc_prev_1;
  logic [12:0] enc_prev_2;
  logic [12:0] enc_prev_3;
  logic signed [15:0] speed_0;
  logic signed [15:0] speed_1;
  logic signed [15:0] speed_2;
  logic signed [15:0] speed_3;

  modport source (output valid, enc_now_0, enc_now_1, enc_now_2, enc_now_3,
                  enc_prev_0, enc_prev_1, enc_prev_2, enc_prev_3,
                  speed_0, speed_1, speed_2, speed_3, input ready);
  modport sink (input valid, enc_now_0, enc_now_1, enc_now_2, enc_now_3,
                enc_prev_0, enc_prev_1, enc_prev_2, enc_prev_3,
                speed_0, speed_1, speed_2, speed_3, output ready);
endinterface

[rtl/cpvp_out_if.sv]
interface cpvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_0;
  logic signed [14:0] drive_1;
  logic signed [14:0] drive_2;
  logic signed [14:0] drive_3;
  logic signed [31:0] scaled_pos_0;
  logic signed [31:0] scaled_pos_1;
  logic signed [31:0] scaled_pos_2;
  logic signed [31:0] scaled_pos_3;
  logic               settled;

  modport source (output valid, drive_0, drive_1, drive_2, drive_3,
                  scaled_pos_0, scaled_pos_1, scaled_pos_2, scaled_pos_3,
                  settled, input ready);
  modport sink (input valid, drive_0, drive_1, drive_2, drive_3,
                scaled_pos_0, scaled_pos_1, scaled_pos_2, scaled_pos_3,
                settled, output ready);
endinterface

[rtl/cascade_position_velocity_pid_core.sv]
// Cascaded position/velocity PID for up to four motors.
// in_ch carries one control tick per beat: current and previous 13-bit encoder
// angle and measured speed of each motor. out_ch returns one beat per tick:
// the saturated current command and the scaled position of each motor, plus
// a settled flag.
// cfg_we/cfg_index/cfg_wdata write the position targets, deadband and
// clamps; write them only while no tick is in flight.
// Schedule: a tick runs each motor in turn (unwrap, scale, error, two
// multiply steps, two sums, velocity error) through one shared datapath
// with one integral-gain multiplier, then a publish step raises
// out_ch.valid; a new tick is taken only after the last one is published.
// in_ch.ready rises again once a result has moved to the output register.
// A finished result waits in the output register while the receiver stalls;
// the next tick is still accepted and computed, and holds in the publish
// step until the output register frees up.
// Reset: synchronous, active low; clears all loop state and restores the
// register defaults (targets 0, deadband 10, limits 3000/10000/3000).
module cascade_position_velocity_pid_core #(
  parameter int MOTORS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cpvp_in_if.sink                             in_ch,
  cpvp_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cpvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpvp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import cpvp_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;

  logic [ENC_W-1:0]         enc_now  [NCH];
  logic [ENC_W-1:0]         enc_prev [NCH];
  logic signed [SPD_W-1:0]  speed    [NCH];
  logic signed [DRV_W-1:0]  drive    [NCH];
  logic signed [SPOS_W-1:0] spos     [NCH];
  logic                     settled;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tgt           <= '0;
      cfg_r.deadband      <= DEADBAND_RST;
      cfg_r.speed_limit   <= SPD_LIM_RST;
      cfg_r.pi_limit      <= PI_LIM_RST;
      cfg_r.current_limit <= CUR_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_TGT0, CFG_TGT1, CFG_TGT2, CFG_TGT3: cfg_r.tgt[cfg_index[1:0]] <= cfg_wdata;
        CFG_DEADBAND: cfg_r.deadband      <= cfg_wdata[DB_W-1:0];
        CFG_SPD_LIM:  cfg_r.speed_limit   <= cfg_wdata[SLIM_W-1:0];
        CFG_PI_LIM:   cfg_r.pi_limit      <= cfg_wdata[PIL_W-1:0];
        CFG_CUR_LIM:  cfg_r.current_limit <= cfg_wdata[CLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // gather the beat into per-motor arrays
  assign enc_now[0]  = in_ch.enc_now_0;
  assign enc_now[1]  = in_ch.enc_now_1;
  assign enc_now[2]  = in_ch.enc_now_2;
  assign enc_now[3]  = in_ch.enc_now_3;
  assign enc_prev[0] = in_ch.enc_prev_0;
  assign enc_prev[1] = in_ch.enc_prev_1;
  assign enc_prev[2] = in_ch.enc_prev_2;
  assign enc_prev[3] = in_ch.enc_prev_3;
  assign speed[0]    = in_ch.speed_0;
  assign speed[1]    = in_ch.speed_1;
  assign speed[2]    = in_ch.speed_2;
  assign speed[3]    = in_ch.speed_3;

  cpvp_ctrl #(.MOTORS(MOTORS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cpvp_dp #(.MOTORS(MOTORS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .enc_now  (enc_now),
    .enc_prev (enc_prev),
    .speed    (speed),
    .drive    (drive),
    .spos     (spos),
    .settled  (settled)
  );

  // spread the result over the output beat
  assign out_ch.drive_0      = drive[0];
  assign out_ch.drive_1      = drive[1];
  assign out_ch.drive_2      = drive[2];
  assign out_ch.drive_3      = drive[3];
  assign out_ch.scaled_pos_0 = spos[0];
  assign out_ch.scaled_pos_1 = spos[1];
  assign out_ch.scaled_pos_2 = spos[2];
  assign out_ch.scaled_pos_3 = spos[3];
  assign out_ch.settled      = settled;

  // one tick at a time: ready drops right after an accepted beat
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a tick is in flight");

  // a new result only appears after a publish step
  a_pub_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.publish))
    else $error("result valid without publish");

  // drive of motor 0 stays inside the current clamp
  a_drv_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.drive_0 <= $signed({1'b0, cfg_r.current_limit}) &&
                      out_ch.drive_0 >= -$signed({1'b0, cfg_r.current_limit})))
    else $error("drive outside current limit");

endmodule

[rtl/cpvp_ctrl.sv]
module cpvp_ctrl #(
  parameter int MOTORS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output cpvp_pkg::cmd_t cmd
);
  import cpvp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUB} state_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [MOT_W-1:0] motor_r, motor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             publish;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign publish   = (state_r == ST_PUB) && (!out_valid_r || out_ready);

  assign cmd.load    = in_valid && in_ready;
  assign cmd.run     = (state_r == ST_RUN);
  assign cmd.phase   = phase_r;
  assign cmd.motor   = motor_r;
  assign cmd.publish = publish;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    motor_nxt     = motor_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          phase_nxt = PH_RAW;
          motor_nxt = '0;
        end
      end
      ST_RUN: begin
        if (phase_r == PH_VACC) begin
          phase_nxt = PH_RAW;
          if (motor_r == MOT_W'(MOTORS - 1)) begin
            state_nxt = ST_PUB;
          end else begin
            motor_nxt = motor_r + 1'b1;
          end
        end else begin
          phase_nxt = phase_t'(phase_r + 3'd1);
        end
      end
      ST_PUB: begin
        if (publish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_RAW;
      motor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      motor_r     <= motor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/cpvp_dp.sv]
module cpvp_dp #(
  parameter int MOTORS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpvp_pkg::cmd_t                      cmd,
  input  cpvp_pkg::cfg_t                      cfg,
  input  logic [cpvp_pkg::ENC_W-1:0]          enc_now  [cpvp_pkg::NCH],
  input  logic [cpvp_pkg::ENC_W-1:0]          enc_prev [cpvp_pkg::NCH],
  input  logic signed [cpvp_pkg::SPD_W-1:0]   speed    [cpvp_pkg::NCH],
  output logic signed [cpvp_pkg::DRV_W-1:0]   drive    [cpvp_pkg::NCH],
  output logic signed [cpvp_pkg::SPOS_W-1:0]  spos     [cpvp_pkg::NCH],
  output logic                                settled
);
  import cpvp_pkg::*;

  localparam int MIW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // captured tick
  logic [ENC_W-1:0]         now_r  [NCH];
  logic [ENC_W-1:0]         prev_r [NCH];
  logic signed [SPD_W-1:0]  spd_r  [NCH];

  // loop state per motor
  logic signed [RAW_W-1:0]  raw_r  [MOTORS];
  logic signed [PI_W-1:0]   pi_r   [MOTORS];
  logic signed [ERR_W-1:0]  pep_r  [MOTORS];
  logic signed [VI_W-1:0]   vi_r   [MOTORS];
  logic signed [ERR_W-1:0]  vep_r  [MOTORS];

  // working results and output register
  logic signed [DRV_W-1:0]  wdrv_r [NCH];
  logic signed [SPOS_W-1:0] wpos_r [NCH];
  logic                     wset_r;
  logic signed [DRV_W-1:0]  odrv_r [NCH];
  logic signed [SPOS_W-1:0] opos_r [NCH];
  logic                     oset_r;

  // per-motor scratch
  logic signed [ERR_W-1:0]  err_r;
  logic                     dead_r;
  logic signed [PI_W-1:0]   pinew_r;
  logic signed [VTGT_W-1:0] vtgt_r;
  logic signed [ERR_W-1:0]  ve_r;
  logic signed [VI_W-1:0]   vinew_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [MIW-1:0]           mi;
  logic [MOT_W-1:0]         mc;

  logic signed [ENC_W+1:0]  stp, alt, step_sel;
  logic [ENC_W+1:0]         stp_abs, alt_abs;
  logic signed [RAW_W-1:0]  raw_nxt;
  logic signed [RAW_W+6:0]  rp_ext, rp100, rp_bias;
  logic signed [SPOS_W-1:0] spos_nxt;
  logic signed [33:0]       pdiff;
  logic [33:0]              pdiff_abs;
  logic signed [ERR_W-1:0]  err_nxt;
  logic [ERR_W:0]           err_abs;
  logic signed [PI_W:0]     psum, plim, nplim;
  logic signed [PI_W-1:0]   pinew_nxt;
  logic [SPD_W:0]           spd_abs;
  logic                     unsettled;
  logic signed [PI_W-1:0]   mop;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc, acc_b;
  logic signed [21:0]       q;
  logic signed [21:0]       lim22;
  logic signed [VTGT_W-1:0] vtgt_nxt;
  logic signed [17:0]       vdiff, vsum;
  logic signed [ERR_W-1:0]  ve_nxt;
  logic signed [VI_W-1:0]   vinew_nxt;
  logic signed [DRV_W-1:0]  drv_nxt;

  assign mc = cmd.motor;
  assign mi = mc[MIW-1:0];

  // encoder step, unwrapped the shorter way round
  always_comb begin
    stp      = $signed({2'b0, now_r[mc]}) - $signed({2'b0, prev_r[mc]});
    alt      = (stp > 0) ? stp - (ENC_W+2)'(ENC_COUNTS) : stp + (ENC_W+2)'(ENC_COUNTS);
    stp_abs  = stp[ENC_W+1] ? (ENC_W+2)'(-stp) : stp;
    alt_abs  = alt[ENC_W+1] ? (ENC_W+2)'(-alt) : alt;
    step_sel = (alt_abs < stp_abs) ? alt : stp;
    raw_nxt  = raw_r[mi] + RAW_W'(step_sel);
  end

  // scaled = raw * 100 / 8192, toward zero
  always_comb begin
    rp_ext   = (RAW_W+7)'(raw_r[mi]);
    rp100    = (rp_ext <<< 6) + (rp_ext <<< 5) + (rp_ext <<< 2);
    rp_bias  = rp100 + (rp100[RAW_W+6] ? (RAW_W+7)'(ENC_COUNTS - 1) : '0);
    spos_nxt = rp_bias[ENC_SHIFT +: SPOS_W];
  end

  // position error, deadband, integral
  always_comb begin
    pdiff     = 34'($signed(cfg.tgt[mc])) - 34'(wpos_r[mc]);
    pdiff_abs = pdiff[33] ? 34'(-pdiff) : pdiff;
    if (pdiff > 34'sd32767) begin
      err_nxt = 16'sh7fff;
    end else if (pdiff < -34'sd32768) begin
      err_nxt = 16'sh8000;
    end else begin
      err_nxt = pdiff[ERR_W-1:0];
    end
    err_abs   = err_nxt[ERR_W-1] ? (ERR_W+1)'(-(ERR_W+1)'(err_nxt)) : (ERR_W+1)'(err_nxt);
    psum      = (PI_W+1)'(pi_r[mi]) + (PI_W+1)'(err_nxt);
    plim      = $signed({2'b0, cfg.pi_limit});
    nplim     = -plim;
    if (psum > plim) begin
      pinew_nxt = plim[PI_W-1:0];
    end else if (psum < nplim) begin
      pinew_nxt = nplim[PI_W-1:0];
    end else begin
      pinew_nxt = psum[PI_W-1:0];
    end
    spd_abs   = spd_r[mc][SPD_W-1] ? (SPD_W+1)'(-(SPD_W+1)'(spd_r[mc]))
                                   : (SPD_W+1)'(spd_r[mc]);
    unsettled = (pdiff_abs > 34'(SETTLE_POS)) || (spd_abs > (SPD_W+1)'(SETTLE_SPD));
  end

  // shared integral-gain multiplier
  always_comb begin
    mop      = (cmd.phase == PH_VMUL) ? PI_W'(vinew_r) : pinew_r;
    prod_nxt = PROD_W'(mop) * PROD_W'(KI_Q16);
  end

  // Q16 sum, truncated toward zero, then clamped
  always_comb begin
    if (cmd.phase == PH_PACC) begin
      acc   = (ACC_W'(err_r) <<< 17) + ACC_W'(prod_r)
            + ((ACC_W'(err_r) - ACC_W'(pep_r[mi])) <<< 17);
      lim22 = $signed({8'b0, cfg.speed_limit});
    end else begin
      acc   = (ACC_W'(ve_r) <<< 17) + ACC_W'(prod_r)
            + ((ACC_W'(ve_r) - ACC_W'(vep_r[mi])) <<< 15);
      lim22 = $signed({8'b0, cfg.current_limit});
    end
    acc_b = acc + (acc[ACC_W-1] ? ACC_W'(65535) : '0);
    q     = acc_b[16 +: 22];
    if (q > lim22) begin
      q = lim22;
    end else if (q < -lim22) begin
      q = -lim22;
    end
    vtgt_nxt = q[VTGT_W-1:0];
    drv_nxt  = q[DRV_W-1:0];
  end

  // velocity error and integral
  always_comb begin
    vdiff = 18'(vtgt_r) - 18'(spd_r[mc]);
    if (vdiff > 18'sd32767) begin
      ve_nxt = 16'sh7fff;
    end else if (vdiff < -18'sd32768) begin
      ve_nxt = 16'sh8000;
    end else begin
      ve_nxt = vdiff[ERR_W-1:0];
    end
    vsum = 18'(vi_r[mi]) + 18'(ve_nxt);
    if (vsum > 18'(VEL_I_LIM)) begin
      vinew_nxt = VI_W'(VEL_I_LIM);
    end else if (vsum < -18'(VEL_I_LIM)) begin
      vinew_nxt = -VI_W'(VEL_I_LIM);
    end else begin
      vinew_nxt = vsum[VI_W-1:0];
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTORS; i++) begin
        raw_r[i] <= '0;
        pi_r[i]  <= '0;
        pep_r[i] <= '0;
        vi_r[i]  <= '0;
        vep_r[i] <= '0;
      end
    end else if (cmd.run) begin
      case (cmd.phase)
        PH_RAW: raw_r[mi] <= raw_nxt;
        PH_PACC: begin
          if (!dead_r) begin
            pi_r[mi]  <= pinew_r;
            pep_r[mi] <= err_r;
          end
        end
        PH_VACC: begin
          vi_r[mi]  <= vinew_r;
          vep_r[mi] <= ve_r;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NCH; i++) begin
        now_r[i]  <= enc_now[i];
        prev_r[i] <= enc_prev[i];
        spd_r[i]  <= speed[i];
        wdrv_r[i] <= '0;
        wpos_r[i] <= '0;
      end
      wset_r <= 1'b1;
    end
    if (cmd.run) begin
      case (cmd.phase)
        PH_SCALE: wpos_r[mc] <= spos_nxt;
        PH_PERR: begin
          err_r   <= err_nxt;
          dead_r  <= (err_abs < (ERR_W+1)'(cfg.deadband));
          pinew_r <= pinew_nxt;
          if (unsettled) begin
            wset_r <= 1'b0;
          end
        end
        PH_PMUL, PH_VMUL: prod_r <= prod_nxt;
        PH_PACC: vtgt_r <= dead_r ? '0 : vtgt_nxt;
        PH_VERR: begin
          ve_r    <= ve_nxt;
          vinew_r <= vinew_nxt;
        end
        PH_VACC: wdrv_r[mc] <= drv_nxt;
        default: ;
      endcase
    end
    if (cmd.publish) begin
      odrv_r <= wdrv_r;
      opos_r <= wpos_r;
      oset_r <= wset_r;
    end
  end

  assign drive   = odrv_r;
  assign spos    = opos_r;
  assign settled = oset_r;

endmodule

[tb/tb_cascade_position_velocity_pid_core.sv]
module tb_cascade_position_velocity_pid_core;
  import cpvp_pkg::*;

  // Q16 loop gains
  localparam longint KP_Q16     = 131072;
  localparam longint KD_POS_Q16 = 131072;
  localparam longint KD_VEL_Q16 = 32768;

  localparam logic [CFG_IDX_W-1:0] TGT_IDX [NCH] = '{CFG_TGT0, CFG_TGT1, CFG_TGT2, CFG_TGT3};

  typedef struct {
    logic [ENC_W-1:0]        now  [NCH];
    logic [ENC_W-1:0]        prev [NCH];
    logic signed [SPD_W-1:0] spd  [NCH];
  } tick_t;

  typedef struct {
    logic signed [DRV_W-1:0]  drive [NCH];
    logic signed [SPOS_W-1:0] spos  [NCH];
    logic                     settled;
  } drive_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cpvp_in_if  in_ch ();
  cpvp_out_if out_ch ();

  cascade_position_velocity_pid_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's registers and loop state
  longint tgt_pos [NCH];
  longint deadband_q, speed_lim_q, pi_lim_q, cur_lim_q;
  logic signed [RAW_W-1:0] raw_pos [NCH];
  longint pos_integ [NCH], pos_err_last [NCH], vel_integ [NCH], vel_err_last [NCH];

  drive_cmd_t pending_cmds [$];
  int         errors;
  bit         idle_on;
  bit         long_hold;
  logic [ENC_W-1:0] enc_track [NCH];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint clampl(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint magl(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Advance the shadow loop state by one tick and return the command it yields
  function automatic drive_cmd_t advance_cascade(tick_t t);
    drive_cmd_t r;
    longint step, alt, rp, scaled, err, vtgt, acc, ve, drv;
    logic [63:0] q;
    r.settled = 1'b1;
    for (int m = 0; m < NCH; m++) begin
      step = longint'(t.now[m]) - longint'(t.prev[m]);
      alt  = (step > 0) ? step - ENC_COUNTS : step + ENC_COUNTS;
      // tie keeps the raw difference
      if (magl(alt) < magl(step)) step = alt;
      raw_pos[m] = raw_pos[m] + step[RAW_W-1:0];
      rp = raw_pos[m];
      q  = (rp * 100) / ENC_COUNTS;
      scaled = longint'(signed'(q[31:0]));

      err = clampl(tgt_pos[m] - scaled, -32768, 32767);
      if (magl(err) < deadband_q) begin
        vtgt = 0;
      end else begin
        pos_integ[m] = clampl(pos_integ[m] + err, -pi_lim_q, pi_lim_q);
        acc = KP_Q16 * err + KI_Q16 * pos_integ[m] + KD_POS_Q16 * (err - pos_err_last[m]);
        pos_err_last[m] = err;
        vtgt = clampl(acc / 65536, -speed_lim_q, speed_lim_q);
      end

      ve = clampl(vtgt - longint'(t.spd[m]), -32768, 32767);
      vel_integ[m] = clampl(vel_integ[m] + ve, -VEL_I_LIM, VEL_I_LIM);
      acc = KP_Q16 * ve + KI_Q16 * vel_integ[m] + KD_VEL_Q16 * (ve - vel_err_last[m]);
      vel_err_last[m] = ve;
      drv = clampl(acc / 65536, -cur_lim_q, cur_lim_q);

      if (magl(tgt_pos[m] - scaled) > SETTLE_POS || magl(longint'(t.spd[m])) > SETTLE_SPD)
        r.settled = 1'b0;
      r.drive[m] = drv[DRV_W-1:0];
      r.spos[m]  = scaled[SPOS_W-1:0];
    end
    return r;
  endfunction

  // Write one register at a falling edge; block must be idle
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DEADBAND: deadband_q  = val & 64'h3FF;
      CFG_SPD_LIM:  speed_lim_q = val & 64'h3FFF;
      CFG_PI_LIM:   pi_lim_q    = val & 64'hFFFFF;
      CFG_CUR_LIM:  cur_lim_q   = val & 64'h3FFF;
      default:      tgt_pos[idx] = longint'(signed'(val[TGT_W-1:0]));
    endcase
  endtask

  task automatic set_limits(longint db, longint sl, longint pil, longint cl);
    cfg_write(CFG_DEADBAND, db);
    cfg_write(CFG_SPD_LIM, sl);
    cfg_write(CFG_PI_LIM, pil);
    cfg_write(CFG_CUR_LIM, cl);
  endtask

  // Hold until every command is back, then let the pipeline drain
  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // Offer one beat, after a random gap when idle_on is set; predict at the accepting edge
  task automatic send_tick(tick_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.enc_now_0 = t.now[0];  in_ch.enc_prev_0 = t.prev[0];  in_ch.speed_0 = t.spd[0];
    in_ch.enc_now_1 = t.now[1];  in_ch.enc_prev_1 = t.prev[1];  in_ch.speed_1 = t.spd[1];
    in_ch.enc_now_2 = t.now[2];  in_ch.enc_prev_2 = t.prev[2];  in_ch.speed_2 = t.spd[2];
    in_ch.enc_now_3 = t.now[3];  in_ch.enc_prev_3 = t.prev[3];  in_ch.speed_3 = t.spd[3];
    do @(posedge clk); while (!in_ch.ready);
    pending_cmds.push_back(advance_cascade(t));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Well-formed tick: prev is the last reading, step mostly small
  function automatic tick_t motion_tick(int max_step, int spd_span);
    tick_t t;
    int s;
    for (int m = 0; m < NCH; m++) begin
      s = $urandom_range(0, 2 * max_step) - max_step;
      if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 8191) - 4096;
      t.prev[m] = enc_track[m];
      t.now[m]  = enc_track[m] + s[ENC_W-1:0];
      enc_track[m] = t.now[m];
      s = $urandom_range(0, 2 * spd_span) - spd_span;
      t.spd[m] = (spd_span >= 32768) ? SPD_W'($urandom) : s[SPD_W-1:0];
    end
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    for (int m = 0; m < NCH; m++) begin
      t.now[m]  = ENC_W'($urandom);
      t.prev[m] = ENC_W'($urandom);
      t.spd[m]  = SPD_W'($urandom);
    end
    return t;
  endfunction

  // Receiver: random stall per beat when idle_on is set, one long hold on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready = 1'b0;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 13) : 0;
      out_ch.ready = (n == 0);
      if (n != 0) begin
        repeat (n) @(negedge clk);
        out_ch.ready = 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    drive_cmd_t e;
    logic signed [DRV_W-1:0]  got_drv [NCH];
    logic signed [SPOS_W-1:0] got_pos [NCH];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_drv = '{out_ch.drive_0, out_ch.drive_1, out_ch.drive_2, out_ch.drive_3};
      got_pos = '{out_ch.scaled_pos_0, out_ch.scaled_pos_1,
                  out_ch.scaled_pos_2, out_ch.scaled_pos_3};
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected beat on out_ch", $time);
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        for (int m = 0; m < NCH; m++) begin
          if (got_drv[m] !== e.drive[m]) begin
            $display("%0t: drive_%0d expected %0d actual %0d", $time, m, e.drive[m], got_drv[m]);
            errors++;
          end
          if (got_pos[m] !== e.spos[m]) begin
            $display("%0t: scaled_pos_%0d expected %0d actual %0d", $time, m, e.spos[m],
                     got_pos[m]);
            errors++;
          end
        end
        if (out_ch.settled !== e.settled) begin
          $display("%0t: settled expected %0b actual %0b", $time, e.settled, out_ch.settled);
          errors++;
        end
      end
    end
  end

  // Extremes of every field, wrap and tie steps, settle edge, saturation
  task automatic test_directed();
    tick_t t;
    int nows  [10] = '{0, 8191, 0, 4096, 0, 8191, 100, 4095, 4097, 12};
    int prevs [10] = '{0, 0, 8191, 0, 4096, 8191, 90, 0, 0, 12};
    int spds  [10] = '{0, 32767, -32768, 100, -100, 101, -101, 1, -1, 0};
    idle_on = 1'b0;
    for (int i = 0; i < 10; i++) begin
      for (int m = 0; m < NCH; m++) begin
        t.now[m] = ENC_W'(nows[i]); t.prev[m] = ENC_W'(prevs[i]); t.spd[m] = SPD_W'(spds[i]);
      end
      send_tick(t);
    end
    wait_drained();
    // huge errors to saturate both loops, then zero limits
    cfg_write(CFG_TGT0, 1000000);
    cfg_write(CFG_TGT1, -1000000);
    cfg_write(CFG_TGT2, 1048575);
    cfg_write(CFG_TGT3, -1048576);
    set_limits(1023, 16383, 1000000, 16383);
    for (int i = 0; i < 5; i++) send_tick(noise_tick());
    wait_drained();
    set_limits(0, 0, 0, 0);
    for (int i = 0; i < 5; i++) send_tick(noise_tick());
    wait_drained();
    for (int m = 0; m < NCH; m++) cfg_write(TGT_IDX[m], 0);
    set_limits(1023, 16383, 1048575, 16383);
    for (int i = 0; i < 4; i++) send_tick(noise_tick());
    wait_drained();
  endtask

  // Random registers per phase, mostly well-formed motion
  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph % 3 != 1);
      for (int m = 0; m < NCH; m++)
        cfg_write(TGT_IDX[m], (ph % 4 == 0) ? longint'($urandom_range(0, 200)) - 100 :
                                longint'($urandom_range(0, 2000000)) - 1000000);
      set_limits($urandom_range(0, 1023), $urandom_range(0, 16383),
                 (ph == 5) ? 0 : $urandom_range(0, 1000000), $urandom_range(0, 16383));
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 9) == 0) send_tick(noise_tick());
        else if (ph % 4 == 0) send_tick(motion_tick(3, 120));
        else send_tick(motion_tick(300, ($urandom_range(0, 3) == 0) ? 32768 : 3000));
      end
      wait_drained();
    end
  endtask

  // Stall the receiver long enough that the block backs up into in_ch
  task automatic test_backpressure();
    idle_on = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_tick(motion_tick(50, 500));
    wait_drained();
  endtask

  initial begin
    errors = 0; idle_on = 1'b0; long_hold = 1'b0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.enc_now_0 = '0; in_ch.enc_now_1 = '0; in_ch.enc_now_2 = '0; in_ch.enc_now_3 = '0;
    in_ch.enc_prev_0 = '0; in_ch.enc_prev_1 = '0; in_ch.enc_prev_2 = '0; in_ch.enc_prev_3 = '0;
    in_ch.speed_0 = '0; in_ch.speed_1 = '0; in_ch.speed_2 = '0; in_ch.speed_3 = '0;
    for (int m = 0; m < NCH; m++) begin
      tgt_pos[m] = 0; raw_pos[m] = '0; pos_integ[m] = 0; pos_err_last[m] = 0;
      vel_integ[m] = 0; vel_err_last[m] = 0; enc_track[m] = '0;
    end
    deadband_q = DEADBAND_RST; speed_lim_q = SPD_LIM_RST;
    pi_lim_q = PI_LIM_RST; cur_lim_q = CUR_LIM_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random_phases();
    test_backpressure();

    wait_drained();
    if (errors == 0) $display("tb_cascade_position_velocity_pid_core OK");
    else $display("tb_cascade_position_velocity_pid_core NOT OK");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_cascade_position_velocity_pid_core NOT OK");
    $finish;
  end

endmodule
